@@ hdl/dld_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dld_pkg: shared types for the OSA edit distance engine
// Holds the row bank code and the command group from the controller to
// the datapath.
// ---------------------------------------------------------------------------
package dld_pkg;

   // Width of the distance field on the response port.
   localparam int DIST_W = 7;

   // Three row buffers rotate through the roles two-back, one-back, current.
   typedef logic [1:0] bank_type;
   localparam bank_type BANK_0 = 2'd0;
   localparam bank_type BANK_1 = 2'd1;
   localparam bank_type BANK_2 = 2'd2;

   typedef struct packed {
      logic load;       // a request is accepted this cycle
      logic clear;      // lengths and overflow flag return to zero
      logic init_wr;    // write the base row entry j with value j
      logic issue;      // issue the reads for cell (i, j)
      logic first_row;  // the issued cell belongs to row one
   } dld_cmd_type;

endpackage

@@ hdl/damerau_levenshtein_distance.sv @@
`timescale 1ns / 1ps
// A pair with an empty string is answered from the check state after its closing request.
// Otherwise the strobe follows the closing request after the base row fill, a sweep over
// every DP cell through a read-then-update cell pipeline, a drain state and a finish state.
// Requests are taken one per cycle while loading; busy stays high during the sweep.
// Reset (synchronous, active high) empties both strings and clears the overflow flag.
// Results cannot be stalled: each is shown for one cycle under rsp_strobe.
// ---------------------------------------------------------------------------
// damerau_levenshtein_distance: OSA edit distance engine
// Loads two byte strings one character per request and, after the request
// that closes a pair, returns their restricted Damerau-Levenshtein distance.
// ---------------------------------------------------------------------------
module damerau_levenshtein_distance
   import dld_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_string_sel,
   input  logic [7:0]          req_char_byte,
   input  logic                req_has_char,
   input  logic                req_end_of_pair,
   output logic                rsp_strobe,
   output logic [DIST_W - 1:0] rsp_distance,
   output logic                rsp_too_long
);

   localparam int LW = $clog2(MAX_LEN + 1);

   // Command group and index lines from the sequencer to the datapath.
   dld_cmd_type     cmd;
   logic [LW - 1:0] cmd_i, cmd_j;
   bank_type        ob_bank, tb_bank, cur_bank;

   // Status back from the datapath: string lengths, overflow and the last cell.
   logic [LW - 1:0] first_len, second_len, result_dist;
   logic            overflow;

   // The sequencer fills row zero, then issues one cell per cycle, row by row,
   // and rotates the three row buffers at the end of each row.
   dld_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_end_of_pair (req_end_of_pair),
      .first_len       (first_len),
      .second_len      (second_len),
      .overflow        (overflow),
      .result_dist     (result_dist),
      .busy            (busy),
      .cmd             (cmd),
      .cmd_i           (cmd_i),
      .cmd_j           (cmd_j),
      .ob_bank         (ob_bank),
      .tb_bank         (tb_bank),
      .cur_bank        (cur_bank),
      .rsp_strobe      (rsp_strobe),
      .rsp_distance    (rsp_distance),
      .rsp_too_long    (rsp_too_long)
   );

   // The datapath holds the strings and row buffers; the cell value of the
   // last column of the last row is the distance.
   dld_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_string_sel (req_string_sel),
      .req_char_byte  (req_char_byte),
      .req_has_char   (req_has_char),
      .cmd            (cmd),
      .cmd_i          (cmd_i),
      .cmd_j          (cmd_j),
      .ob_bank        (ob_bank),
      .tb_bank        (tb_bank),
      .cur_bank       (cur_bank),
      .first_len      (first_len),
      .second_len     (second_len),
      .overflow       (overflow),
      .result_dist    (result_dist)
   );

endmodule

@@ hdl/dld_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dld_dp: string store, row buffers and cell update of the distance engine
// Keeps both strings and three rotating rows, and runs a two-stage cell
// pipeline: registered reads, then the minimum of the four edit terms.
// ---------------------------------------------------------------------------
module dld_dp
   import dld_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_string_sel,
   input  logic [7:0]                         req_char_byte,
   input  logic                               req_has_char,
   input  dld_cmd_type                        cmd,
   input  logic [$clog2(MAX_LEN + 1) - 1:0]   cmd_i,
   input  logic [$clog2(MAX_LEN + 1) - 1:0]   cmd_j,
   input  bank_type                           ob_bank,
   input  bank_type                           tb_bank,
   input  bank_type                           cur_bank,
   output logic [$clog2(MAX_LEN + 1) - 1:0]   first_len,
   output logic [$clog2(MAX_LEN + 1) - 1:0]   second_len,
   output logic                               overflow,
   output logic [$clog2(MAX_LEN + 1) - 1:0]   result_dist
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [7:0]      first_string_ff  [0:MAX_LEN - 1];
   logic [7:0]      second_string_ff [0:MAX_LEN - 1];
   logic [LW - 1:0] row_ff [0:2][0:MAX_LEN];

   logic [LW - 1:0] first_len_ff, first_len_in;
   logic [LW - 1:0] second_len_ff, second_len_in;
   logic            overflow_ff, overflow_in;

   logic [7:0]      a_rd_ff, b_rd_ff;
   logic [LW - 1:0] ob_rd_ff, tb_rd_ff;

   logic            c_valid_ff;
   logic [LW - 1:0] c_j_ff, c_row_ff;
   logic            c_deep_ff;
   bank_type        c_bank_ff;

   logic [7:0]      ca_ff, ca_prev_ff, b_prev_ff;
   logic [LW - 1:0] left_ff, ob_prev_ff;

   logic [LW - 1:0] i_m1, j_m1, tb_j;
   logic            wr_first, wr_second;
   logic [LW:0]     d_left, d_up, d_diag, d_swap, best;
   logic            swap_ok;
   logic            row_wr;
   bank_type        row_wr_bank;
   logic [LW - 1:0] row_wr_j, row_wr_data;

   // Loading of the strings.
   always_comb begin
      wr_first      = cmd.load && req_has_char && !req_string_sel
                      && (first_len_ff < LW'(MAX_LEN));
      wr_second     = cmd.load && req_has_char && req_string_sel
                      && (second_len_ff < LW'(MAX_LEN));
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      overflow_in   = overflow_ff;
      if (cmd.clear) begin
         first_len_in  = '0;
         second_len_in = '0;
         overflow_in   = 1'b0;
      end else if (cmd.load && req_has_char) begin
         if (wr_first) begin
            first_len_in = first_len_ff + LW'(1);
         end else if (wr_second) begin
            second_len_in = second_len_ff + LW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_string_ff[first_len_ff[AW - 1:0]] <= req_char_byte;
      end
      if (wr_second) begin
         second_string_ff[second_len_ff[AW - 1:0]] <= req_char_byte;
      end
      a_rd_ff <= first_string_ff[i_m1[AW - 1:0]];
      b_rd_ff <= second_string_ff[j_m1[AW - 1:0]];
   end

   // Read addresses of the issue stage.
   always_comb begin
      i_m1 = cmd_i - LW'(1);
      j_m1 = cmd_j - LW'(1);
      tb_j = (cmd_j < LW'(2)) ? '0 : cmd_j - LW'(2);
   end

   // Cell update of the compute stage.
   always_comb begin
      d_left  = {1'b0, left_ff} + (LW + 1)'(1);
      d_up    = {1'b0, ob_rd_ff} + (LW + 1)'(1);
      d_diag  = {1'b0, ob_prev_ff} + (LW + 1)'(ca_ff != b_rd_ff);
      d_swap  = {1'b0, tb_rd_ff} + (LW + 1)'(1);
      swap_ok = c_deep_ff && (c_j_ff > LW'(1)) && (ca_ff == b_prev_ff)
                && (ca_prev_ff == b_rd_ff);
      best    = (d_left < d_up) ? d_left : d_up;
      if (d_diag < best) begin
         best = d_diag;
      end
      if (swap_ok && (d_swap < best)) begin
         best = d_swap;
      end
   end

   // One write port on the row buffers: base row fill or cell result.
   always_comb begin
      row_wr      = 1'b0;
      row_wr_bank = c_bank_ff;
      row_wr_j    = c_j_ff;
      row_wr_data = LW'(best);
      if (cmd.init_wr) begin
         row_wr      = 1'b1;
         row_wr_bank = ob_bank;
         row_wr_j    = cmd_j;
         row_wr_data = cmd_j;
      end else if (c_valid_ff) begin
         row_wr = 1'b1;
         if (c_j_ff == '0) begin
            row_wr_data = c_row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (row_wr) begin
         row_ff[row_wr_bank][row_wr_j] <= row_wr_data;
      end
      ob_rd_ff <= row_ff[ob_bank][cmd_j];
      tb_rd_ff <= row_ff[tb_bank][tb_j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= cmd.issue;
      end
      c_j_ff    <= cmd_j;
      c_row_ff  <= cmd_i;
      c_deep_ff <= !cmd.first_row;
      c_bank_ff <= cur_bank;
      if (c_valid_ff) begin
         ob_prev_ff <= ob_rd_ff;
         b_prev_ff  <= b_rd_ff;
         if (c_j_ff == '0) begin
            left_ff    <= c_row_ff;
            ca_prev_ff <= ca_ff;
            ca_ff      <= a_rd_ff;
         end else begin
            left_ff <= LW'(best);
         end
      end
   end

   assign first_len   = first_len_ff;
   assign second_len  = second_len_ff;
   assign overflow    = overflow_ff;
   assign result_dist = left_ff;

   // A cell never exceeds the longest possible string.
   a_cell_bound: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && (c_j_ff != '0)) |-> (best <= (LW + 1)'(MAX_LEN)))
      else $error("cell value above MAX_LEN");

   // Lengths stay within the store.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (first_len_ff <= LW'(MAX_LEN)) && (second_len_ff <= LW'(MAX_LEN)))
      else $error("string length beyond the store");

   // The base row fill and the cell pipeline never compete for the write port.
   a_wr_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.init_wr |-> !c_valid_ff)
      else $error("row write conflict");

endmodule

@@ hdl/dld_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dld_ctrl: sequencer of the distance engine
// Walks the load, base row fill and row-by-row cell sweep, rotates the row
// buffer roles and drives the response strobe.
// ---------------------------------------------------------------------------
module dld_ctrl
   import dld_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               req_end_of_pair,
   input  logic [$clog2(MAX_LEN + 1) - 1:0]   first_len,
   input  logic [$clog2(MAX_LEN + 1) - 1:0]   second_len,
   input  logic                               overflow,
   input  logic [$clog2(MAX_LEN + 1) - 1:0]   result_dist,
   output logic                               busy,
   output dld_cmd_type                        cmd,
   output logic [$clog2(MAX_LEN + 1) - 1:0]   cmd_i,
   output logic [$clog2(MAX_LEN + 1) - 1:0]   cmd_j,
   output bank_type                           ob_bank,
   output bank_type                           tb_bank,
   output bank_type                           cur_bank,
   output logic                               rsp_strobe,
   output logic [DIST_W - 1:0]                rsp_distance,
   output logic                               rsp_too_long
);

   localparam int LW = $clog2(MAX_LEN + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_INIT,
      S_SWEEP,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [LW - 1:0]     i_ff, i_in, j_ff, j_in;
   bank_type            ob_ff, ob_in, tb_ff, tb_in, cur_ff, cur_in;
   logic                strobe_ff, strobe_in;
   logic [DIST_W - 1:0] dist_ff, dist_in;
   logic                too_long_ff, too_long_in;
   logic                accept;

   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      ob_in       = ob_ff;
      tb_in       = tb_ff;
      cur_in      = cur_ff;
      strobe_in   = 1'b0;
      dist_in     = dist_ff;
      too_long_in = too_long_ff;
      cmd         = '0;
      cmd.load    = accept;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_end_of_pair) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if ((first_len == '0) || (second_len == '0)) begin
               strobe_in   = 1'b1;
               dist_in     = DIST_W'((first_len == '0) ? second_len : first_len);
               too_long_in = overflow;
               cmd.clear   = 1'b1;
               state_in    = S_IDLE;
            end else begin
               j_in     = '0;
               ob_in    = BANK_0;
               cur_in   = BANK_1;
               tb_in    = BANK_2;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init_wr = 1'b1;
            if (j_ff == second_len) begin
               j_in     = '0;
               i_in     = LW'(1);
               state_in = S_SWEEP;
            end else begin
               j_in = j_ff + LW'(1);
            end
         end
         S_SWEEP: begin
            cmd.issue     = 1'b1;
            cmd.first_row = (i_ff == LW'(1));
            if (j_ff == second_len) begin
               j_in = '0;
               if (i_ff == first_len) begin
                  state_in = S_DRAIN;
               end else begin
                  i_in   = i_ff + LW'(1);
                  tb_in  = ob_ff;
                  ob_in  = cur_ff;
                  cur_in = tb_ff;
               end
            end else begin
               j_in = j_ff + LW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            strobe_in   = 1'b1;
            dist_in     = DIST_W'(result_dist);
            too_long_in = overflow;
            cmd.clear   = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      ob_ff       <= ob_in;
      tb_ff       <= tb_in;
      cur_ff      <= cur_in;
      dist_ff     <= dist_in;
      too_long_ff <= too_long_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign cmd_i        = i_ff;
   assign cmd_j        = j_ff;
   assign ob_bank      = ob_ff;
   assign tb_bank      = tb_ff;
   assign cur_bank     = cur_ff;
   assign rsp_strobe   = strobe_ff;
   assign rsp_distance = dist_ff;
   assign rsp_too_long = too_long_ff;

   // The strobe lasts one cycle.
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("response strobe held for more than one cycle");

   // The row index stays within the first string during the sweep.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |->
         ((i_ff >= LW'(1)) && (i_ff <= first_len) && (j_ff <= second_len)))
      else $error("sweep index out of range");

   // Every finished sweep yields exactly one response.
   a_finish_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> (strobe_ff && (state_ff == S_IDLE)))
      else $error("finished sweep without response");

   // The three row roles name distinct buffers during the sweep.
   a_bank_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |->
         ((ob_ff != tb_ff) && (ob_ff != cur_ff) && (tb_ff != cur_ff)))
      else $error("row buffer roles collide");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the OSA edit distance engine
// Feeds string pairs one character per request, predicts each distance with
// a full dynamic-programming grid and checks every strobed result in order.
// Directed pairs come first, then capacity pairs, then random pairs built around
// near-copies so that swaps, substitutions and truncation all show up.
// ---------------------------------------------------------------------------

// Scoreboard: mirrors the two string stores, predicts the distance when a
// pair closes and matches strobed results against the oldest prediction.
class osa_scoreboard #(int CAP = 64);

   localparam int DW = dld_pkg::DIST_W;

   typedef struct packed {
      logic [dld_pkg::DIST_W - 1:0] distance;
      logic                         too_long;
   } distance_result_type;

   logic [7:0]          first_chars [CAP];
   logic [7:0]          second_chars[CAP];
   int                  first_len;
   int                  second_len;
   bit                  truncated;
   int                  cost_grid[CAP + 1][CAP + 1];
   distance_result_type expected_q[$];
   int                  mismatches;
   int                  results_checked;

   function new();
      first_len       = 0;
      second_len      = 0;
      truncated       = 0;
      mismatches      = 0;
      results_checked = 0;
   endfunction

   // Full-grid OSA distance over the stored strings.
   function int edit_distance();
      int best;
      for (int i = 0; i <= first_len; i++) cost_grid[i][0] = i;
      for (int j = 0; j <= second_len; j++) cost_grid[0][j] = j;
      for (int i = 1; i <= first_len; i++) begin
         for (int j = 1; j <= second_len; j++) begin
            best = cost_grid[i - 1][j - 1] + (first_chars[i - 1] != second_chars[j - 1]);
            if (cost_grid[i - 1][j] + 1 < best) best = cost_grid[i - 1][j] + 1;
            if (cost_grid[i][j - 1] + 1 < best) best = cost_grid[i][j - 1] + 1;
            if (i > 1 && j > 1 && first_chars[i - 1] == second_chars[j - 2] &&
                first_chars[i - 2] == second_chars[j - 1] &&
                cost_grid[i - 2][j - 2] + 1 < best)
               best = cost_grid[i - 2][j - 2] + 1;
            cost_grid[i][j] = best;
         end
      end
      return cost_grid[first_len][second_len];
   endfunction

   function void note_request(logic sel, logic [7:0] ch, logic has_char, logic end_of_pair);
      distance_result_type res;
      if (has_char) begin
         if (!sel) begin
            if (first_len < CAP) first_chars[first_len++] = ch;
            else truncated = 1;
         end else begin
            if (second_len < CAP) second_chars[second_len++] = ch;
            else truncated = 1;
         end
      end
      if (end_of_pair) begin
         res.distance = DW'(edit_distance());
         res.too_long = truncated;
         expected_q.insert(expected_q.size(), res);
         first_len  = 0;
         second_len = 0;
         truncated  = 0;
      end
   endfunction

   function void check_result(logic [dld_pkg::DIST_W - 1:0] distance, logic too_long);
      distance_result_type want;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tb_top: unexpected result at %0t: distance %0d too_long %0b",
                     $time, distance, too_long);
         return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (distance !== want.distance || too_long !== want.too_long) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tb_top: mismatch at %0t: distance %0d (want %0d), too_long %0b (want %0b)",
                     $time, distance, want.distance, too_long, want.too_long);
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

endclass

module tb_top;
   import dld_pkg::*;

   localparam int MAX_LEN = 64;
   // The slowest sweep is for two strings of 64 characters; the drain at the end waits as long as that.
   localparam int DRAIN_CYCLES = (MAX_LEN + 1) * (MAX_LEN + 1) + 3;
   // Roughly 900 requests with a 27% idle rate, plus the sweeps, keep a worst-case run
   // of this stimulus well under the limit.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEM_TARGET = 850;

   typedef logic [7:0] byte_queue_type[$];
   typedef enum int {EDIT_SWAP, EDIT_SUBST, EDIT_INSERT, EDIT_DELETE} edit_kind_type;

   logic                clock;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic                busy;
   logic                req_string_sel  = 1'b0;
   logic [7:0]          req_char_byte   = 8'h00;
   logic                req_has_char    = 1'b0;
   logic                req_end_of_pair = 1'b0;
   logic                rsp_strobe;
   logic [DIST_W - 1:0] rsp_distance;
   logic                rsp_too_long;

   osa_scoreboard #(MAX_LEN) board;

   // Request counters. Idle requests (no character, no close) are not counted.
   int  items_sent  = 0;
   int  pairs_sent  = 0;
   int  long_pairs  = 0;
   int  cycle_count = 0;
   bit  idle_on     = 1'b1;

   damerau_levenshtein_distance #(.MAX_LEN(MAX_LEN)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_string_sel  (req_string_sel),
      .req_char_byte   (req_char_byte),
      .req_has_char    (req_has_char),
      .req_end_of_pair (req_end_of_pair),
      .rsp_strobe      (rsp_strobe),
      .rsp_distance    (rsp_distance),
      .rsp_too_long    (rsp_too_long)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both the monitor and the driver run at the rising edge and read the values
   // that were settled before it, since the block and the driver both update by
   // nonblocking assignment. A result is checked before a request of the same edge
   // is noted, so a closing request never sees its own prediction consumed early.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_result(rsp_distance, rsp_too_long);
         if (start && !busy)
            board.note_request(req_string_sel, req_char_byte, req_has_char, req_end_of_pair);
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.pending());
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Presents one request and holds it until the block takes it. While idling is
   // enabled, start drops for a random number of cycles first. Each time step sees
   // at most one assignment to start: low in the idle loop, high once it ends.
   task automatic send_request(input logic sel, input logic [7:0] ch,
                               input logic has_char, input logic end_of_pair);
      while (idle_on && $urandom_range(99) < 27) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_string_sel  <= sel;
      req_char_byte   <= ch;
      req_has_char    <= has_char;
      req_end_of_pair <= end_of_pair;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (has_char || end_of_pair) items_sent++;
      // The middle of the random part runs without any idling at all.
      idle_on = !(items_sent >= 350 && items_sent < 600);
   endtask

   // A small alphabet makes matches and adjacent swaps common; wide mode covers
   // every byte value.
   function automatic logic [7:0] pick_char(bit wide);
      return wide ? 8'($urandom_range(255)) : 8'(8'h61 + $urandom_range(3));
   endfunction

   function automatic byte_queue_type random_string(int len, bit wide);
      byte_queue_type s;
      repeat (len) s.insert(s.size(), pick_char(wide));
      return s;
   endfunction

   // A near-copy of src with a few swaps, substitutions, insertions or deletions.
   function automatic byte_queue_type mutate_string(byte_queue_type src, bit wide);
      byte_queue_type dst;
      int             pos;
      logic [7:0]     tmp;
      edit_kind_type  kind;
      dst = src;
      repeat ($urandom_range(3)) begin
         kind = edit_kind_type'($urandom_range(3));
         case (kind)
            EDIT_SWAP: begin
               if (dst.size() > 1) begin
                  pos          = $urandom_range(dst.size() - 2);
                  tmp          = dst[pos];
                  dst[pos]     = dst[pos + 1];
                  dst[pos + 1] = tmp;
               end
            end
            EDIT_SUBST: begin
               if (dst.size() > 0) dst[$urandom_range(dst.size() - 1)] = pick_char(wide);
            end
            EDIT_INSERT: begin
               dst.insert($urandom_range(dst.size()), pick_char(wide));
            end
            default: begin
               if (dst.size() > 0) dst.delete($urandom_range(dst.size() - 1));
            end
         endcase
      end
      return dst;
   endfunction

   // Sends one pair: characters of the two strings interleave at random, order
   // within each string kept, with a sprinkling of idle requests. The pair closes
   // either on its last character or with a separate request that carries none.
   task automatic run_pair(input byte_queue_type first_s, input byte_queue_type second_s);
      int   ia;
      int   ib;
      int   total;
      bit   attach;
      bit   last;
      logic sel;
      ia     = 0;
      ib     = 0;
      total  = first_s.size() + second_s.size();
      attach = (total > 0) && $urandom_range(1);
      if (first_s.size() > MAX_LEN || second_s.size() > MAX_LEN) long_pairs++;
      while (ia + ib < total) begin
         if ($urandom_range(19) == 0)
            send_request(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0);
         if (ia == first_s.size()) sel = 1'b1;
         else if (ib == second_s.size()) sel = 1'b0;
         else sel = 1'($urandom_range(1));
         last = (ia + ib + 1 == total);
         if (!sel) begin
            send_request(1'b0, first_s[ia], 1'b1, last && attach);
            ia++;
         end else begin
            send_request(1'b1, second_s[ib], 1'b1, last && attach);
            ib++;
         end
      end
      if (!attach) send_request(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b1);
      pairs_sent++;
   endtask

   // Random pair: mostly short strings, some medium ones, a few that reach or pass
   // the capacity. The second string is usually an edited copy of the first.
   task automatic random_pair();
      byte_queue_type first_s;
      byte_queue_type second_s;
      int             size_class;
      int             lo;
      int             hi;
      bit             wide;
      size_class = $urandom_range(99);
      wide       = ($urandom_range(9) < 3);
      if (size_class < 3) begin
         lo = 50;
         hi = 72;
      end else if (size_class < 12) begin
         lo = 9;
         hi = 20;
      end else begin
         lo = 0;
         hi = 6;
      end
      first_s = random_string($urandom_range(hi, lo), wide);
      if ($urandom_range(9) < 6) second_s = mutate_string(first_s, wide);
      else second_s = random_string($urandom_range(hi, lo), wide);
      // Now and then one side stays empty.
      if ($urandom_range(19) == 0) begin
         if ($urandom_range(1)) first_s.delete();
         else second_s.delete();
      end
      run_pair(first_s, second_s);
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- Directed pairs --------------------------------------------------
      // A pair closed with no characters at all gives a distance of zero.
      send_request(1'b0, 8'h00, 1'b0, 1'b1);
      // An idle request changes nothing; then one character that also closes the
      // pair, so the second string is empty and the distance is one.
      send_request(1'b1, 8'hFF, 1'b0, 1'b0);
      send_request(1'b0, 8'h41, 1'b1, 1'b1);
      // Only the second string, holding the byte extremes: distance two.
      send_request(1'b1, 8'h00, 1'b1, 1'b0);
      send_request(1'b1, 8'hFF, 1'b1, 1'b0);
      send_request(1'b0, 8'hA5, 1'b0, 1'b1);
      // Identical strings.
      send_request(1'b0, 8'h61, 1'b1, 1'b0);
      send_request(1'b1, 8'h61, 1'b1, 1'b0);
      send_request(1'b0, 8'h62, 1'b1, 1'b0);
      send_request(1'b1, 8'h62, 1'b1, 1'b1);
      // Adjacent swap "ab" against "ba" costs one.
      send_request(1'b0, 8'h61, 1'b1, 1'b0);
      send_request(1'b0, 8'h62, 1'b1, 1'b0);
      send_request(1'b1, 8'h62, 1'b1, 1'b0);
      send_request(1'b1, 8'h61, 1'b1, 1'b1);
      // Single substitution between the byte extremes.
      send_request(1'b0, 8'h00, 1'b1, 1'b0);
      send_request(1'b1, 8'hFF, 1'b1, 1'b1);
      // "ca" against "abc": the restricted distance is three, not two.
      send_request(1'b0, 8'h63, 1'b1, 1'b0);
      send_request(1'b0, 8'h61, 1'b1, 1'b0);
      send_request(1'b1, 8'h61, 1'b1, 1'b0);
      send_request(1'b1, 8'h62, 1'b1, 1'b0);
      send_request(1'b1, 8'h63, 1'b1, 1'b0);
      send_request(1'b0, 8'h00, 1'b0, 1'b1);

      // ---- Capacity pairs --------------------------------------------------
      // Both strings exactly at capacity: the largest sweep, no truncation.
      run_pair(random_string(MAX_LEN, 1'b1), random_string(MAX_LEN, 1'b0));
      // First string past capacity: the extra characters are dropped and flagged.
      run_pair(random_string(MAX_LEN + 6, 1'b0), random_string(MAX_LEN - 3, 1'b0));

      // ---- Random pairs ----------------------------------------------------
      while (items_sent < ITEM_TARGET) random_pair();

      // Let every outstanding sweep finish, then watch for stray strobes.
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d requests in %0d pairs, %0d of them with an overlong string",
               items_sent, pairs_sent, long_pairs);
      $display("tb_top: %0d distances checked, %0d mismatches",
               board.results_checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
